@@ hw/rtl/ita_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // format codes of the cmd field
    localparam logic [1:0] CMD_UDEC = 2'd0;
    localparam logic [1:0] CMD_SDEC = 2'd1;
    localparam logic [1:0] CMD_OCT  = 2'd2;
    localparam logic [1:0] CMD_HEX  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    // 'A' minus ten, so that digit ten lands on 'A'
    localparam logic [7:0] CH_ALPHA_BASE = 8'h37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE1,
        ST_PRE2,
        ST_CONV,
        ST_DIGITS,
        ST_SPACE
    } state_t;

    typedef enum logic [1:0] {
        DOP_HOLD,
        DOP_LOAD,
        DOP_DABBLE,
        DOP_SHIFT
    } digit_op_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'h0, d};
        if (d < 4'd10)
        begin
            return CH_ZERO + d8;
        end
        return CH_ALPHA_BASE + d8;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ita_digit_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ita_digit_reg #(
    parameter int NUM_DIGITS = (ita_pkg::VALUE_WIDTH_DEF + 2) / 3
) (
    input  wire logic                      clk,
    input  wire ita_pkg::digit_op_t        op,
    input  wire logic [NUM_DIGITS*4-1:0]   load_digits,
    input  wire logic                      bit_in,
    output logic [3:0]                     msd
);
    import ita_pkg::*;

    localparam int DW = NUM_DIGITS * 4;

    logic [DW-1:0] digits_reg;
    logic [DW-1:0] adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digits_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = digits_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = digits_reg[4*i +: 4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            DOP_LOAD:   digits_reg <= load_digits;
            DOP_DABBLE: digits_reg <= {adj[DW-2:0], bit_in};
            DOP_SHIFT:  digits_reg <= {digits_reg[DW-5:0], 4'h0};
            default:    digits_reg <= digits_reg;
        endcase
    end

    assign msd = digits_reg[DW-1 -: 4];

endmodule

`default_nettype wire

@@ hw/rtl/ita_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ita_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ita_pkg::char_t push_data,
    output logic                ready,
    output logic                char_valid,
    input  wire logic           char_stall,
    output logic [7:0]          ascii_char,
    output logic                last
);
    import ita_pkg::*;

    logic  valid_reg;
    char_t data_reg;

    assign ready = !valid_reg || !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && push)
        begin
            data_reg <= push_data;
        end
    end

    assign char_valid = valid_reg;
    assign ascii_char = data_reg.code;
    assign last       = data_reg.last;

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Formats one VALUE_WIDTH-bit operand per request as ASCII text, one character per
// output transfer, most significant digit first, ending with a space flagged by last.
// cmd selects unsigned decimal, signed decimal (leading '-'), octal (leading '0') or
// hex (leading "0x", upper case). A request is taken only while the block is idle;
// after the final space is handed to the output register the next request is taken
// even if that space is still waiting. Decimal runs a bit-serial double-dabble
// conversion over all VALUE_WIDTH bits; every format then walks ceil(VALUE_WIDTH/3)
// digit slots, leading zeros skipped. A request thus passes through its prefix
// characters, the decimal conversion, the digit slots and the final space.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic [1:0]              cmd,
    input  wire logic [VALUE_WIDTH-1:0]  value,
    output logic                         char_valid,
    input  wire logic                    char_stall,
    output logic [7:0]                   ascii_char,
    output logic                         last
);
    import ita_pkg::*;

    localparam int NUM_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int DW         = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [1:0]             fmt_reg, fmt_next;
    logic                   started_reg, started_next;

    digit_op_t        dop;
    logic [DW-1:0]    load_digits;
    logic [DW-1:0]    vpad;
    logic [DW-1:0]    oct_digits;
    logic [3:0]       msd;
    logic             push;
    char_t            push_data;
    logic             push_ok;
    logic             is_dec;
    logic             is_neg;

    assign req_stall = (state_reg != ST_IDLE);
    assign is_dec    = (cmd == CMD_UDEC) || (cmd == CMD_SDEC);
    assign is_neg    = (cmd == CMD_SDEC) && value[VALUE_WIDTH-1];
    assign vpad      = DW'(value);

    // each 3-bit octal digit goes into a nibble slot of its own
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            oct_digits[4*i +: 4] = {1'b0, vpad[3*i +: 3]};
        end
    end

    always_comb
    begin
        case (cmd)
            CMD_OCT: load_digits = oct_digits;
            CMD_HEX: load_digits = vpad;
            default: load_digits = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        fmt_reg <= fmt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        fmt_next       = fmt_reg;
        started_next   = started_reg;
        dop            = DOP_HOLD;
        push           = 1'b0;
        push_data.code = CH_SPACE;
        push_data.last = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    fmt_next     = cmd;
                    started_next = 1'b0;
                    dop          = DOP_LOAD;
                    if (is_neg)
                    begin
                        mag_next = {VALUE_WIDTH{1'b0}} - value;
                    end
                    else
                    begin
                        mag_next = value;
                    end
                    if (is_dec)
                    begin
                        cnt_next = CNT_W'(VALUE_WIDTH);
                    end
                    else
                    begin
                        cnt_next = CNT_W'(NUM_DIGITS);
                    end
                    if (is_neg || !is_dec)
                    begin
                        state_next = ST_PRE1;
                    end
                    else
                    begin
                        state_next = ST_CONV;
                    end
                end
            end

            ST_PRE1:
            begin
                push_data.code = (fmt_reg == CMD_SDEC) ? CH_MINUS : CH_ZERO;
                push           = 1'b1;
                if (push_ok)
                begin
                    if (fmt_reg == CMD_HEX)
                    begin
                        state_next = ST_PRE2;
                    end
                    else if (fmt_reg == CMD_OCT)
                    begin
                        state_next = ST_DIGITS;
                    end
                    else
                    begin
                        state_next = ST_CONV;
                    end
                end
            end

            ST_PRE2:
            begin
                push_data.code = CH_X;
                push           = 1'b1;
                if (push_ok)
                begin
                    state_next = ST_DIGITS;
                end
            end

            ST_CONV:
            begin
                dop      = DOP_DABBLE;
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(NUM_DIGITS);
                    state_next = ST_DIGITS;
                end
            end

            ST_DIGITS:
            begin
                push_data.code = digit_char(msd);
                // the final slot always prints, so zero still gives one digit
                if (started_reg || (msd != 4'h0) || (cnt_reg == CNT_W'(1)))
                begin
                    push = 1'b1;
                    if (push_ok)
                    begin
                        dop          = DOP_SHIFT;
                        started_next = 1'b1;
                        cnt_next     = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            state_next = ST_SPACE;
                        end
                    end
                end
                else
                begin
                    dop      = DOP_SHIFT;
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ST_SPACE:
            begin
                push_data.code = CH_SPACE;
                push_data.last = 1'b1;
                push           = 1'b1;
                if (push_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ita_digit_reg #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digits (
        .clk         (clk),
        .op          (dop),
        .load_digits (load_digits),
        .bit_in      (mag_reg[VALUE_WIDTH-1]),
        .msd         (msd)
    );

    ita_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .ready      (push_ok),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    a_last_is_space: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last |-> ascii_char == CH_SPACE)
        else $error("last flag on a character other than space");

    a_digit_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS) || (state_reg == ST_CONV) |-> cnt_reg != '0)
        else $error("slot counter empty while converting or emitting");

    a_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS) && (cnt_reg == CNT_W'(1)) && push_ok
        |=> state_reg == ST_SPACE)
        else $error("final digit slot not followed by the space");

    a_req_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != ST_IDLE)
        else $error("request accepted without starting a run");

endmodule

`default_nettype wire

@@ test/tb_integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

    import ita_pkg::*;

    localparam int NUM_RANDOM  = 480;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_TICKS = 80;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_TICKS  = 300;

    class format_checker;
        char_t pending_chars[$];
        int    errors;
        int    chars_checked;
        int    per_format[4];

        function void note_request(logic [1:0] fmt, logic [31:0] operand);
            logic [31:0] mag;
            logic [31:0] base;
            logic [31:0] digit;
            logic [7:0]  digits[$];
            char_t       ch;
            base = 32'd10;
            mag  = operand;
            per_format[fmt]++;
            ch.last = 1'b0;
            case (fmt)
                CMD_UDEC: ;
                CMD_SDEC:
                begin
                    if (operand[31])
                    begin
                        ch.code = CH_MINUS;
                        pending_chars.push_back(ch);
                        // two's complement magnitude, exact for the most negative value
                        mag = 32'd0 - operand;
                    end
                end
                CMD_OCT:
                begin
                    base = 32'd8;
                    ch.code = CH_ZERO;
                    pending_chars.push_back(ch);
                end
                default:
                begin
                    base = 32'd16;
                    ch.code = CH_ZERO;
                    pending_chars.push_back(ch);
                    ch.code = CH_X;
                    pending_chars.push_back(ch);
                end
            endcase
            if (mag == 32'd0)
                digits.push_front(CH_ZERO);
            while (mag != 32'd0)
            begin
                digit = mag % base;
                if (digit < 32'd10)
                    digits.push_front(CH_ZERO + digit[7:0]);
                else
                    digits.push_front("A" + digit[7:0] - 8'd10);
                mag = mag / base;
            end
            foreach (digits[i])
            begin
                ch.code = digits[i];
                pending_chars.push_back(ch);
            end
            ch.code = CH_SPACE;
            ch.last = 1'b1;
            pending_chars.push_back(ch);
        endfunction

        function void check_char(logic [7:0] code, logic is_last);
            char_t want;
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected char 0x%02h last=%0b", code, is_last);
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code || is_last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: char #%0d expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             chars_checked, want.code, want.last, code, is_last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  cmd;
    logic [31:0] value;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  ascii_char;
    logic        last;

    format_checker fmt_chk;
    int            idle_ticks;
    int            sent;

    integer_to_ascii_formatter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cmd        (cmd),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // accepted requests and characters, sampled before the edge updates
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            fmt_chk.note_request(cmd, value);
        if (rst_n && char_valid && !char_stall)
            fmt_chk.check_char(ascii_char, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (char_valid && !char_stall))
            idle_ticks <= 0;
        else
            idle_ticks <= idle_ticks + 1;
        if (idle_ticks == IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // gap of zero keeps valid high straight into the next request
    task automatic send_request(input logic [1:0] fmt, input logic [31:0] operand,
                                input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= fmt;
        value     <= operand;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    // receiver side: random stalls, bursts with none, one long hold-off
    initial
    begin
        int got;
        int hold;
        got = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (got == HOLD_AT)
                hold = HOLD_TICKS;
            else if (got % 100 >= 75)
                hold = 0;
            else
                hold = $urandom_range(0, 8);
            if (hold > 0)
            begin
                char_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                char_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!char_valid);
            got++;
        end
    end

    initial
    begin
        logic [31:0] corners[4];
        logic [31:0] operand;
        logic [1:0]  fmt;
        int          gap;
        corners[0] = 32'h0000_0000;
        corners[1] = 32'h7FFF_FFFF;
        corners[2] = 32'h8000_0000;
        corners[3] = 32'hFFFF_FFFF;
        fmt_chk    = new();
        sent       = 0;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        cmd        <= CMD_UDEC;
        value      <= 32'd0;
        char_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, largest positive, most negative, all ones in every format
        foreach (corners[i])
        begin
            send_request(CMD_UDEC, corners[i], $urandom_range(0, 8));
            send_request(CMD_SDEC, corners[i], $urandom_range(0, 8));
            send_request(CMD_OCT, corners[i], $urandom_range(0, 8));
            send_request(CMD_HEX, corners[i], $urandom_range(0, 8));
        end
        send_request(CMD_UDEC, 32'd9, 0);
        send_request(CMD_UDEC, 32'd10, 0);
        send_request(CMD_SDEC, 32'd1, 1);
        send_request(CMD_OCT, 32'd8, 2);
        send_request(CMD_HEX, 32'hABCD_EF0F, 0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            fmt = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: operand = $urandom;
                1: operand = $urandom_range(0, 20);
                2: operand = 32'd1 << $urandom_range(0, 31);
                3: operand = ~(32'd1 << $urandom_range(0, 31));
                default: operand = $urandom >> $urandom_range(0, 31);
            endcase
            gap = (i % 64 >= 48) ? 0 : $urandom_range(0, 8);
            send_request(fmt, operand, gap);
        end
        req_valid <= 1'b0;

        while (fmt_chk.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (fmt_chk.pending_chars.size() != 0)
        begin
            fmt_chk.errors++;
            $display("ERROR: %0d chars never arrived", fmt_chk.pending_chars.size());
        end
        $display("covered %0d requests: udec %0d, sdec %0d, oct %0d, hex %0d",
                 sent, fmt_chk.per_format[0], fmt_chk.per_format[1],
                 fmt_chk.per_format[2], fmt_chk.per_format[3]);
        $display("checked %0d chars with random stalls and one long hold, %0d mismatches",
                 fmt_chk.chars_checked, fmt_chk.errors);
        if (fmt_chk.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
